FILE: rtl/gfc_pkg.sv
// ----------------------------------------------------------------------------
// gfc_pkg
// shared types and constants of the gated frequency counter
// ----------------------------------------------------------------------------
package gfc_pkg;

  typedef enum logic [1:0] {
    CMD_EDGE = 2'd0,
    CMD_TICK = 2'd1,
    CMD_BYTE = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [0:0] {
    REG_GATE_TICKS = 1'b0,
    REG_CAL_GAIN   = 1'b1
  } reg_idx_e;

  localparam int unsigned CountW    = 32;
  localparam int unsigned TickW     = 16;
  localparam int unsigned GainW     = 31;
  localparam int unsigned GainFracW = 30;
  localparam int unsigned SelW      = 2;
  localparam int unsigned CfgDataW  = 31;

  localparam logic [TickW-1:0] GateTicksReset = 16'd1000;
  localparam logic [GainW-1:0] CalGainReset   = 31'd1073746119;

  // console letters in upper case, and the bounds of the lower-case range
  localparam logic [7:0] CharA = 8'h41;
  localparam logic [7:0] CharC = 8'h43;
  localparam logic [7:0] CharD = 8'h44;
  localparam logic [7:0] CharH = 8'h48;
  localparam logic [7:0] CharM = 8'h4d;
  localparam logic [7:0] CharT = 8'h54;
  localparam logic [7:0] CharLowA = 8'h61;
  localparam logic [7:0] CharLowZ = 8'h7a;

  // one processed beat on its way to the calibration stage
  typedef struct packed {
    logic              latch_en;
    logic [CountW-1:0] count;
    logic              hold;
    logic              led;
    logic [SelW-1:0]   clk_sel;
    logic              gate_done;
    logic              clear_req;
  } step_t;

endpackage

FILE: rtl/gfc_cfg_regs.sv
// ----------------------------------------------------------------------------
// gfc_cfg_regs
// gate length and calibration gain registers
// ----------------------------------------------------------------------------
module gfc_cfg_regs import gfc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [0:0]          wr_index_i,
  input  logic [CfgDataW-1:0] wr_data_i,
  output logic [TickW-1:0]    gate_ticks_o,
  output logic [GainW-1:0]    cal_gain_o
);

  logic [TickW-1:0] gate_ticks_q;
  logic [GainW-1:0] cal_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_ticks_q <= GateTicksReset;
      cal_gain_q   <= CalGainReset;
    end else if (wr_en_i) begin
      case (reg_idx_e'(wr_index_i))
        REG_GATE_TICKS: gate_ticks_q <= wr_data_i[TickW-1:0];
        REG_CAL_GAIN:   cal_gain_q   <= wr_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  assign gate_ticks_o = gate_ticks_q;
  assign cal_gain_o   = cal_gain_q;

endmodule

FILE: rtl/gfc_state.sv
// ----------------------------------------------------------------------------
// gfc_state
// counters, hold, led and clock select; decodes one beat per step
// ----------------------------------------------------------------------------
module gfc_state import gfc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_en_i,
  input  logic [1:0]       command_i,
  input  logic [7:0]       byte_value_i,
  input  logic [TickW-1:0] gate_ticks_i,
  output step_t            step_o
);

  logic [CountW-1:0] event_q, event_d;
  logic [TickW-1:0]  tick_q, tick_d;
  logic              hold_q, hold_d;
  logic              led_q, led_d;
  logic [SelW-1:0]   sel_q, sel_d;

  logic [TickW:0]    tick_next;
  logic [TickW:0]    limit;
  logic [7:0]        up_char;
  logic              gate_end;
  logic              clear_req;

  always_comb begin
    tick_next = {1'b0, tick_q} + {{TickW{1'b0}}, 1'b1};
    limit     = (gate_ticks_i == '0) ? {{TickW{1'b0}}, 1'b1} : {1'b0, gate_ticks_i};
    // fold lower case onto upper case
    up_char   = ((byte_value_i >= CharLowA) && (byte_value_i <= CharLowZ))
                ? (byte_value_i & 8'hdf) : byte_value_i;

    event_d   = event_q;
    tick_d    = tick_q;
    hold_d    = hold_q;
    led_d     = led_q;
    sel_d     = sel_q;
    gate_end  = 1'b0;
    clear_req = 1'b0;

    case (cmd_e'(command_i))
      CMD_EDGE: event_d = event_q + 32'd1;
      CMD_TICK: begin
        if (tick_next >= limit) begin
          gate_end = 1'b1;
          tick_d   = '0;
          event_d  = '0;
          led_d    = ~led_q;
        end else begin
          tick_d = tick_next[TickW-1:0];
        end
      end
      CMD_BYTE: begin
        case (up_char)
          CharA:   led_d = 1'b1;
          CharD:   led_d = 1'b0;
          CharT:   led_d = ~led_q;
          CharC:   clear_req = 1'b1;
          CharM:   sel_d = sel_q + 2'd1;
          CharH:   hold_d = ~hold_q;
          default: ;
        endcase
      end
      default: ;
    endcase

    step_o.latch_en  = gate_end & ~hold_q;
    step_o.count     = event_q;
    step_o.hold      = hold_d;
    step_o.led       = led_d;
    step_o.clk_sel   = sel_d;
    step_o.gate_done = gate_end;
    step_o.clear_req = clear_req;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      event_q <= '0;
      tick_q  <= '0;
      hold_q  <= 1'b0;
      led_q   <= 1'b0;
      sel_q   <= '0;
    end else if (step_en_i) begin
      event_q <= event_d;
      tick_q  <= tick_d;
      hold_q  <= hold_d;
      led_q   <= led_d;
      sel_q   <= sel_d;
    end
  end

endmodule

FILE: rtl/gfc_calib.sv
// ----------------------------------------------------------------------------
// gfc_calib
// count times q1.30 gain, saturated to 32 bits, into the frequency latch
// ----------------------------------------------------------------------------
module gfc_calib import gfc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic              latch_en_i,
  input  logic [CountW-1:0] count_i,
  input  logic [GainW-1:0]  gain_i,
  output logic [CountW-1:0] freq_o
);

  localparam int unsigned ProdW = CountW + GainW;

  logic [ProdW-1:0]          prod;
  logic [ProdW-GainFracW-1:0] scaled;
  logic [CountW-1:0]         sat;
  logic [CountW-1:0]         freq_q, freq_d;

  always_comb begin
    prod   = {{GainW{1'b0}}, count_i} * {{CountW{1'b0}}, gain_i};
    scaled = prod[ProdW-1:GainFracW];
    // anything past 32 bits clips to all ones
    sat    = (scaled[ProdW-GainFracW-1:CountW] != '0) ? '1 : scaled[CountW-1:0];
    freq_d = (load_i && latch_en_i) ? sat : freq_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= '0;
    end else begin
      freq_q <= freq_d;
    end
  end

  assign freq_o = freq_q;

endmodule

FILE: rtl/gated_frequency_counter.sv
// ----------------------------------------------------------------------------
// gated_frequency_counter
// frequency meter core: edge counting, gated latch with calibration, console
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_ready_o): one beat carries command_i and
//   byte_value_i; edge, millisecond tick or console byte
//   output channel (out_valid_o / out_ready_i): exactly one result beat per
//   input beat, in order, reporting the state after that beat
//   config channel (cfg_valid_i / cfg_ready_o): index 0 gate length in ticks,
//   index 1 q1.30 calibration gain; always ready, write only while idle
// timing
//   three register stages: input register, state update into a step register,
//   then the 32x31 calibration multiply into the result register; out_valid_o
//   rises as the beat enters the result register; one beat per cycle while
//   out_ready_i is high, and the multiply sits alone in the last stage
// reset
//   counters, latch, hold, led and clock select clear; gate length 1000 and
//   gain about 1.000004; all stages empty
// stall
//   when out_ready_i is low the result holds and empty stages still fill, so
//   up to three beats are taken before in_ready_o drops
// ----------------------------------------------------------------------------
module gated_frequency_counter import gfc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input beats
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          command_i,
  input  logic [7:0]          byte_value_i,
  // result beats
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CountW-1:0]   frequency_o,
  output logic                hold_on_o,
  output logic                led_on_o,
  output logic [SelW-1:0]     clock_out_select_o,
  output logic                gate_done_o,
  output logic                clear_request_o,
  // register writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [0:0]          cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  logic [TickW-1:0] gate_ticks;
  logic [GainW-1:0] cal_gain;

  // stage 1: input register
  logic       s1_v_q;
  logic [1:0] s1_cmd_q;
  logic [7:0] s1_byte_q;
  // stage 2: processed step
  logic       s2_v_q;
  step_t      s2_q;
  step_t      step;
  // stage 3: result register (frequency lives in the calibration unit)
  logic            out_v_q;
  logic            out_hold_q;
  logic            out_led_q;
  logic [SelW-1:0] out_sel_q;
  logic            out_gate_q;
  logic            out_clr_q;

  logic out_adv, s2_adv, s1_adv;
  logic s1_fire, s2_fire;

  // a stage moves when it is empty or its content moves on
  assign out_adv = ~out_v_q | out_ready_i;
  assign s2_adv  = ~s2_v_q | out_adv;
  assign s1_adv  = ~s1_v_q | s2_adv;
  assign s1_fire = s1_v_q & s2_adv;
  assign s2_fire = s2_v_q & out_adv;

  assign in_ready_o  = s1_adv;
  assign cfg_ready_o = 1'b1;

  gfc_cfg_regs u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (cfg_valid_i),
    .wr_index_i   (cfg_index_i),
    .wr_data_i    (cfg_wdata_i),
    .gate_ticks_o (gate_ticks),
    .cal_gain_o   (cal_gain)
  );

  // state advances exactly once per beat, as it leaves the input register
  gfc_state u_state (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_en_i    (s1_fire),
    .command_i    (s1_cmd_q),
    .byte_value_i (s1_byte_q),
    .gate_ticks_i (gate_ticks),
    .step_o       (step)
  );

  // frequency latch updates as the step enters the result register
  gfc_calib u_calib (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (s2_fire),
    .latch_en_i (s2_q.latch_en),
    .count_i    (s2_q.count),
    .gain_i     (cal_gain),
    .freq_o     (frequency_o)
  );

  // valid bits of the three stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_q <= in_valid_i;
      end
      if (s2_adv) begin
        s2_v_q <= s1_v_q;
      end
      if (out_adv) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s1_cmd_q  <= command_i;
      s1_byte_q <= byte_value_i;
    end
    if (s2_adv) begin
      s2_q <= step;
    end
    if (s2_fire) begin
      out_hold_q <= s2_q.hold;
      out_led_q  <= s2_q.led;
      out_sel_q  <= s2_q.clk_sel;
      out_gate_q <= s2_q.gate_done;
      out_clr_q  <= s2_q.clear_req;
    end
  end

  assign out_valid_o        = out_v_q;
  assign hold_on_o          = out_hold_q;
  assign led_on_o           = out_led_q;
  assign clock_out_select_o = out_sel_q;
  assign gate_done_o        = out_gate_q;
  assign clear_request_o    = out_clr_q;

`ifndef ASSERT_OFF
  // a latch request only comes from a gate end outside hold
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && s2_q.latch_en) |-> (s2_q.gate_done && !s2_q.hold))
    else $error("latch request without gate end or in hold");

  // the frequency only moves together with a gate-end result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && $past(out_v_q) && (frequency_o != $past(frequency_o))) |-> gate_done_o)
    else $error("frequency changed without gate end");

  // one beat is either a tick or a byte, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(gate_done_o && clear_request_o))
    else $error("gate end and clear request in one result");

  // an empty result register never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");
`endif

endmodule

FILE: dv/gated_frequency_counter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gated_frequency_counter_tb
// self-checking bench: random and directed edge, tick and console beats,
// register writes between phases, every result compared with a local model
// ----------------------------------------------------------------------------
module gated_frequency_counter_tb;
  import gfc_pkg::*;

  // one input beat as queued for the driver
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] ch;
  } meter_beat_t;

  // one result beat, as the meter reports it
  typedef struct packed {
    logic [CountW-1:0] freq;
    logic              hold;
    logic              led;
    logic [SelW-1:0]   sel;
    logic              gate_done;
    logic              clear_req;
  } meter_reading_t;

  localparam int unsigned StallLimit = 5000;  // cycles with no beat on any channel
  localparam int unsigned DrainCycles = 8;    // three stages plus margin
  localparam int unsigned PhaseBeats = 185;

  // ports; those the bench drives are known from time zero
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          command = CMD_EDGE;
  logic [7:0]          byte_value = 8'h00;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CountW-1:0]   frequency;
  logic                hold_on;
  logic                led_on;
  logic [SelW-1:0]     clock_out_select;
  logic                gate_done;
  logic                clear_request;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [0:0]          cfg_index = REG_GATE_TICKS;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  // model state of the meter and its two registers
  logic [TickW-1:0]    gate_len;
  logic [GainW-1:0]    cal_gain;
  logic [CountW-1:0]   edge_total;
  logic [TickW-1:0]    tick_total;
  logic [CountW-1:0]   latched_freq;
  logic                hold_state;
  logic                led_state;
  logic [SelW-1:0]     sel_state;

  meter_beat_t         pending_beats[$];
  meter_reading_t      expected_readings[$];

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned beats_taken = 0;
  int unsigned readings_seen = 0;
  int unsigned gate_ends = 0;
  int unsigned reg_writes = 0;
  int unsigned quiet_cycles = 0;

  meter_reading_t got, want;

  gated_frequency_counter DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .command_i          (command),
    .byte_value_i       (byte_value),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .frequency_o        (frequency),
    .hold_on_o          (hold_on),
    .led_on_o           (led_on),
    .clock_out_select_o (clock_out_select),
    .gate_done_o        (gate_done),
    .clear_request_o    (clear_request),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_wdata_i        (cfg_wdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // count times gain in q1.30, fraction dropped, clipped to 32 bits
  function automatic logic [CountW-1:0] calibrated_count(logic [CountW-1:0] cnt,
                                                         logic [GainW-1:0] gain);
    logic [63:0] prod;
    logic [63:0] scaled;
    prod = {32'b0, cnt} * {33'b0, gain};
    scaled = prod >> GainFracW;
    if (scaled > 64'hffff_ffff) begin
      return '1;
    end
    return scaled[CountW-1:0];
  endfunction

  // apply one beat to the model state and return the reading it produces
  function automatic meter_reading_t step_meter(cmd_e cmd, logic [7:0] ch);
    meter_reading_t r;
    logic [16:0]    next_tick;
    logic [16:0]    limit;
    logic [7:0]     upper;
    r.gate_done = 1'b0;
    r.clear_req = 1'b0;
    case (cmd)
      CMD_EDGE: begin
        edge_total = edge_total + 32'd1;
      end
      CMD_TICK: begin
        next_tick = {1'b0, tick_total} + 17'd1;
        // a gate length of zero acts as one
        limit = (gate_len == '0) ? 17'd1 : {1'b0, gate_len};
        // also catches a gate length lowered below the running tick count
        if (next_tick >= limit) begin
          r.gate_done = 1'b1;
          tick_total = '0;
          if (!hold_state) begin
            latched_freq = calibrated_count(edge_total, cal_gain);
          end
          edge_total = '0;
          led_state = ~led_state;
          gate_ends++;
        end else begin
          tick_total = next_tick[TickW-1:0];
        end
      end
      CMD_BYTE: begin
        upper = (ch >= CharLowA && ch <= CharLowZ) ? ch - 8'd32 : ch;
        case (upper)
          CharA: led_state = 1'b1;
          CharD: led_state = 1'b0;
          CharT: led_state = ~led_state;
          CharC: r.clear_req = 1'b1;
          CharM: sel_state = sel_state + 2'd1;  // 3 wraps to 0
          CharH: hold_state = ~hold_state;
          default: ;
        endcase
      end
      default: ;  // unused command code leaves the state alone
    endcase
    r.freq = latched_freq;
    r.hold = hold_state;
    r.led  = led_state;
    r.sel  = sel_state;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_val,
                                      logic [31:0] act_val);
    if (exp_val !== act_val) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
    end
  endfunction

  // mostly edges and ticks, with letters of either case, some noise bytes
  // and the unused command code
  function automatic meter_beat_t random_beat();
    meter_beat_t b;
    logic [7:0]  letter;
    int unsigned pick;
    pick = $urandom_range(99);
    b.ch = 8'($urandom);
    letter = CharA;
    if (pick < 50) begin
      b.cmd = CMD_EDGE;
    end else if (pick < 74) begin
      b.cmd = CMD_TICK;
    end else if (pick < 90) begin
      b.cmd = CMD_BYTE;
      case ($urandom_range(5))
        0: letter = CharA;
        1: letter = CharC;
        2: letter = CharD;
        3: letter = CharH;
        4: letter = CharM;
        default: letter = CharT;
      endcase
      b.ch = ($urandom_range(1) == 1) ? letter + 8'd32 : letter;
    end else if (pick < 96) begin
      b.cmd = CMD_BYTE;
    end else begin
      b.cmd = CMD_NONE;
    end
    return b;
  endfunction

  // driver: take a beat off the queue, hold it until accepted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        expected_readings.push_back(step_meter(cmd_e'(command), byte_value));
        beats_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid   <= 1'b1;
          command    <= pending_beats[0].cmd;
          byte_value <= pending_beats[0].ch;
          pending_beats.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result beat with the oldest expected reading
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        readings_seen++;
        got = '{frequency, hold_on, led_on, clock_out_select, gate_done, clear_request};
        if (expected_readings.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with nothing expected, actual %h", $time, got);
        end else begin
          want = expected_readings.pop_front();
          check_field("frequency", want.freq, got.freq);
          check_field("hold_on", 32'(want.hold), 32'(got.hold));
          check_field("led_on", 32'(want.led), 32'(got.led));
          check_field("clock_out_select", 32'(want.sel), 32'(got.sel));
          check_field("gate_done", 32'(want.gate_done), 32'(got.gate_done));
          check_field("clear_request", 32'(want.clear_req), 32'(got.clear_req));
        end
      end
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // watchdog on cycles in which no channel moves a beat
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no progress for %0d cycles", $time, StallLimit);
      $display("gated_frequency_counter verification failed");
      $finish;
    end
  end

  // one register write; the model copy follows at the accepting edge
  task automatic write_reg(reg_idx_e idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == REG_GATE_TICKS) begin
      gate_len = data[TickW-1:0];
    end else begin
      cal_gain = data[GainW-1:0];
    end
    reg_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic push_beat(cmd_e cmd, logic [7:0] ch);
    pending_beats.push_back('{cmd, ch});
  endtask

  // wait until every queued beat has gone through and its result came back
  task automatic drain();
    while (pending_beats.size() > 0 || in_valid || expected_readings.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    gate_len     = GateTicksReset;
    cal_gain     = CalGainReset;
    edge_total   = '0;
    tick_total   = '0;
    latched_freq = '0;
    hold_state   = 1'b0;
    led_state    = 1'b0;
    sel_state    = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: field extremes, unused command, every letter, all but A and D in both cases
    push_beat(CMD_EDGE, 8'h00);
    push_beat(CMD_EDGE, 8'hff);
    push_beat(CMD_NONE, 8'hff);
    push_beat(CMD_TICK, 8'h80);
    push_beat(CMD_BYTE, CharA);
    push_beat(CMD_BYTE, CharD + 8'd32);
    push_beat(CMD_BYTE, CharT);
    push_beat(CMD_BYTE, CharT + 8'd32);
    push_beat(CMD_BYTE, CharM);
    push_beat(CMD_BYTE, CharM + 8'd32);
    push_beat(CMD_BYTE, CharM);
    push_beat(CMD_BYTE, CharM);             // select wraps back to 0
    push_beat(CMD_BYTE, CharH);
    push_beat(CMD_BYTE, CharH + 8'd32);
    push_beat(CMD_BYTE, CharC);
    push_beat(CMD_BYTE, CharC + 8'd32);
    push_beat(CMD_BYTE, 8'h00);             // bytes that are no letter command
    push_beat(CMD_BYTE, 8'hff);
    push_beat(CMD_BYTE, CharA - 8'd1);
    drain();

    // zero gate length: each tick closes a gate
    write_reg(REG_GATE_TICKS, '0);
    push_beat(CMD_EDGE, 8'h5a);
    push_beat(CMD_TICK, 8'h00);
    push_beat(CMD_TICK, 8'h00);
    drain();

    // longest gate and largest gain, then a gate length below the tick count
    write_reg(REG_GATE_TICKS, 31'd65535);
    write_reg(REG_CAL_GAIN, 31'h7fff_ffff);
    push_beat(CMD_EDGE, 8'h00);
    push_beat(CMD_TICK, 8'h00);
    push_beat(CMD_TICK, 8'h00);
    push_beat(CMD_TICK, 8'h00);
    drain();
    write_reg(REG_GATE_TICKS, 31'd2);
    push_beat(CMD_TICK, 8'h00);
    drain();

    // zero gain latches zero
    write_reg(REG_CAL_GAIN, '0);
    write_reg(REG_GATE_TICKS, 31'd1);
    push_beat(CMD_EDGE, 8'h00);
    push_beat(CMD_TICK, 8'h00);
    drain();

    // random phases, one per flow-control mode, each with its own settings
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
          write_reg(REG_GATE_TICKS, 31'd1);
          write_reg(REG_CAL_GAIN, CalGainReset);
        end
        1: begin
          sender_idle_pct = 54;
          receiver_stall_pct = 0;
          write_reg(REG_GATE_TICKS, CfgDataW'($urandom_range(12, 2)));
          write_reg(REG_CAL_GAIN, CfgDataW'($urandom));
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 54;
          write_reg(REG_GATE_TICKS, CfgDataW'($urandom_range(25, 5)));
          write_reg(REG_CAL_GAIN, 31'h7fff_ffff);
        end
        default: begin
          sender_idle_pct = 22;
          receiver_stall_pct = 22;
          write_reg(REG_GATE_TICKS, 31'd7);
          write_reg(REG_CAL_GAIN, CfgDataW'($urandom_range(32'h4000_0000)));
        end
      endcase
      repeat (PhaseBeats) pending_beats.push_back(random_beat());
      drain();
    end

    $display("ran %0d input beats and checked %0d results over %0d gate ends",
             beats_taken, readings_seen, gate_ends);
    $display("with %0d register writes across four flow-control phases", reg_writes);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("gated_frequency_counter verification clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches,
               expected_readings.size());
      $display("gated_frequency_counter verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/gfc_pkg.sv
rtl/gfc_cfg_regs.sv
rtl/gfc_state.sv
rtl/gfc_calib.sv
rtl/gated_frequency_counter.sv
dv/gated_frequency_counter_tb.sv
